// File: hdl/itoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the microcode table of the integer to ASCII
// converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 7;

    // Default digit limit.
    localparam int MAX_DIGITS_DEF = 64;

    // Divider: quotient bits produced per cycle, and divider chunks per digit.
    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = VALUE_W / DIV_BITS;
    localparam int CHUNK_W    = $clog2(DIV_CHUNKS);

    // Radix limits and character codes.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    // Microprogram step counter.
    localparam int PC_W = 3;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_WAIT     = 3'd0,
        OP_DIV_INIT = 3'd1,
        OP_DIV_STEP = 3'd2,
        OP_STORE    = 3'd3,
        OP_SIGN     = 3'd4,
        OP_READ     = 3'd5,
        OP_EMIT     = 3'd6,
        OP_NOP      = 3'd7
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_ALWAYS      = 3'd1,
        COND_NOT_START   = 3'd2,
        COND_CHUNK_MORE  = 3'd3,
        COND_MORE_DIGITS = 3'd4,
        COND_NOT_LAST    = 3'd5
    } cond_t;

    // One control word.
    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Status returned from the datapath to the sequencer.
    typedef struct packed {
        logic chunk_more;
        logic more_digits;
        logic not_last;
    } status_t;

    // Step addresses.
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_DIVI = 3'd1;
    localparam logic [PC_W-1:0] PC_DIVS = 3'd2;
    localparam logic [PC_W-1:0] PC_STOR = 3'd3;
    localparam logic [PC_W-1:0] PC_SIGN = 3'd4;
    localparam logic [PC_W-1:0] PC_READ = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd6;
    localparam logic [PC_W-1:0] PC_DONE = 3'd7;

    // The microprogram. A jump is taken when its condition holds, otherwise
    // the step counter moves to the next word.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            PC_IDLE: w = '{op: OP_WAIT,     cond: COND_NOT_START,   target: PC_IDLE};
            PC_DIVI: w = '{op: OP_DIV_INIT, cond: COND_NEVER,       target: PC_IDLE};
            PC_DIVS: w = '{op: OP_DIV_STEP, cond: COND_CHUNK_MORE,  target: PC_DIVS};
            PC_STOR: w = '{op: OP_STORE,    cond: COND_MORE_DIGITS, target: PC_DIVI};
            PC_SIGN: w = '{op: OP_SIGN,     cond: COND_NEVER,       target: PC_IDLE};
            PC_READ: w = '{op: OP_READ,     cond: COND_NEVER,       target: PC_IDLE};
            PC_EMIT: w = '{op: OP_EMIT,     cond: COND_NOT_LAST,    target: PC_READ};
            PC_DONE: w = '{op: OP_NOP,      cond: COND_ALWAYS,      target: PC_IDLE};
            default: w = '{op: OP_NOP,      cond: COND_ALWAYS,      target: PC_IDLE};
        endcase
        return w;
    endfunction

    // Digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
            c = CHAR_ZERO + {2'b00, d};
        else
            c = CHAR_ALPHA + {2'b00, d - DIGIT_TEN};
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/itoa_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_useq
// Microprogram sequencer: step counter, control word table and jump logic.
// ----------------------------------------------------------------------------
module itoa_useq
    import itoa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output ucode_t       ctrl,
    output logic         busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    // Fetch the control word for the current step.
    assign ctrl = ucode_rom(pc_reg);
    assign busy = (pc_reg != PC_IDLE);

    // Evaluate the jump condition.
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:       take = 1'b0;
            COND_ALWAYS:      take = 1'b1;
            COND_NOT_START:   take = !start;
            COND_CHUNK_MORE:  take = status.chunk_more;
            COND_MORE_DIGITS: take = status.more_digits;
            COND_NOT_LAST:    take = status.not_last;
            default:          take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule
`default_nettype wire

// File: hdl/itoa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_datapath
// Magnitude register, radix divider, digit store and output register,
// all driven by the control word of the sequencer.
// ----------------------------------------------------------------------------
module itoa_datapath
    import itoa_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ucode_t                    ctrl,
    input  wire logic                      start,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [RADIX_W-1:0]        radix,
    output status_t                        status,
    output logic                           strobe,
    output logic [CHAR_W-1:0]              character,
    output logic                           last,
    output logic [LEN_W-1:0]               length
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_DIGITS);
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(DIV_CHUNKS - 1);

    // Working registers.
    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] mag_next;
    logic [RADIX_W-1:0] rad_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic [RADIX_W-1:0] rem_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic               neg_reg;
    logic [RADIX_W-1:0] rd_reg;

    // Output register.
    logic               strobe_reg;
    logic [CHAR_W-1:0]  character_reg;
    logic               last_reg;
    logic [LEN_W-1:0]   length_reg;

    // Digit store.
    logic [RADIX_W-1:0] digit_mem [MAX_DIGITS];

    logic               load;
    logic [RADIX_W-1:0] rad_in;
    logic               neg_in;
    logic [CW-1:0]      count_inc;
    logic [CW:0]        total;
    logic [AW-1:0]      rd_addr;

    assign load = (ctrl.op == OP_WAIT) && start;

    // Radix clamp and sign decision for a new item.
    always_comb
    begin
        if (radix < RADIX_MIN)
            rad_in = RADIX_MIN;
        else if (radix > RADIX_MAX)
            rad_in = RADIX_MAX;
        else
            rad_in = radix;
        neg_in = (rad_in == RADIX_DEC) && value[VALUE_W-1];
    end

    // Restoring division by the radix, DIV_BITS quotient bits per cycle.
    always_comb
    begin
        logic [RADIX_W:0]   trial;
        logic [VALUE_W-1:0] m;
        logic [RADIX_W-1:0] r;
        m = mag_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r, m[VALUE_W-1]};
            if (trial >= {1'b0, rad_reg})
            begin
                trial = trial - {1'b0, rad_reg};
                m     = {m[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                m     = {m[VALUE_W-2:0], 1'b0};
            end
            r = trial[RADIX_W-1:0];
        end
        mag_next = m;
        rem_next = r;
    end

    assign count_inc = count_reg + 1'b1;
    assign total     = {1'b0, count_reg} + {{CW{1'b0}}, neg_reg};
    assign rd_addr   = AW'(idx_reg - 1'b1);

    // Status for the jump conditions.
    assign status.chunk_more  = (chunk_reg != CHUNK_LAST);
    assign status.more_digits = (mag_reg != '0) && (count_inc != COUNT_LIMIT);
    assign status.not_last    = (idx_reg != CW'(1));

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (ctrl.op)
                OP_WAIT:
                begin
                    if (load)
                    begin
                        neg_reg   <= neg_in;
                        count_reg <= '0;
                    end
                end
                OP_DIV_INIT: chunk_reg <= '0;
                OP_DIV_STEP: chunk_reg <= chunk_reg + 1'b1;
                OP_STORE:    count_reg <= count_inc;
                OP_SIGN:
                begin
                    idx_reg    <= count_reg;
                    strobe_reg <= neg_reg;
                end
                OP_READ:     ;
                OP_EMIT:
                begin
                    idx_reg    <= idx_reg - 1'b1;
                    strobe_reg <= 1'b1;
                end
                default:     ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_WAIT:
            begin
                if (load)
                begin
                    rad_reg <= rad_in;
                    mag_reg <= neg_in ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
                end
            end
            OP_DIV_INIT: rem_reg <= '0;
            OP_DIV_STEP:
            begin
                mag_reg <= mag_next;
                rem_reg <= rem_next;
            end
            OP_STORE:    digit_mem[count_reg[AW-1:0]] <= rem_reg;
            OP_SIGN:
            begin
                character_reg <= CHAR_MINUS;
                last_reg      <= 1'b0;
                length_reg    <= '0;
            end
            OP_READ:     rd_reg <= digit_mem[rd_addr];
            OP_EMIT:
            begin
                character_reg <= ascii_of_digit(rd_reg);
                last_reg      <= (idx_reg == CW'(1));
                length_reg    <= (idx_reg == CW'(1)) ? LEN_W'(total) : '0;
            end
            default:     ;
        endcase
    end

    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign length    = length_reg;

endmodule
`default_nettype wire

// File: hdl/integer_to_ascii_radix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a 64-bit integer to ASCII text in radix 2 to 36, one character
// per result, most significant character first.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the whole text has been sent. Each character appears for exactly one
// cycle with strobe high and must be captured then, since there is no way to
// hold results back. A '-' leads negative values in radix 10 only; any other
// radix reads the value as unsigned. The radix is clamped to 2..36. The last
// character has last set and carries the total length. For each digit, the
// sequencer initialises the radix divider, steps it until the digit is done
// (eight quotient bits per cycle), and writes the remainder to the digit
// store. A sign step follows; then each digit is read back from the digit
// store and sent, most significant first, and one closing step completes
// the item.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [RADIX_W-1:0]        radix,
    output logic                           strobe,
    output logic [CHAR_W-1:0]              character,
    output logic                           last,
    output logic [LEN_W-1:0]               length
);

    ucode_t  ctrl;
    status_t status;

    // Microprogram sequencer.
    itoa_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // Divider, digit store and output register.
    itoa_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .start     (start),
        .value     (value),
        .radix     (radix),
        .status    (status),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .length    (length)
    );

endmodule
`default_nettype wire
